[src/slcr_pkg.sv]
package slcr_pkg;

    localparam int HEAD_BYTES  = 32;
    localparam int LEN_W       = $clog2(HEAD_BYTES + 1);
    localparam int NUM_PAT     = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] BYTE_LF = 8'd10;
    localparam logic [7:0] BYTE_CR = 8'd13;

    localparam logic [1:0] PIN_BOARD = 2'b01;
    localparam logic [1:0] PIN_PANEL = 2'b10;

    localparam int CMD_POS     = 8;
    localparam int VERB_POS    = 14;
    localparam int ON_DEV_POS  = 17;
    localparam int OFF_DEV_POS = 18;

    localparam int LEN_MARKER = 7;
    localparam int LEN_POWER  = 5;
    localparam int LEN_LCD    = 3;
    localparam int LEN_RESET  = 20;
    localparam int LEN_ON     = 2;
    localparam int LEN_OFF    = 3;
    localparam int LEN_BOARD  = 6;

    localparam logic [8*LEN_MARKER-1:0] STR_MARKER = {"#!# ", 8'h41, 8'h56, 8'h52};
    localparam logic [8*LEN_POWER-1:0]  STR_POWER  = "power";
    localparam logic [8*LEN_LCD-1:0]    STR_LCD    = "lcd";
    localparam logic [8*LEN_RESET-1:0]  STR_RESET  =
        {"REALLY reset the ", 8'h41, 8'h56, 8'h52};
    localparam logic [8*LEN_ON-1:0]     STR_ON     = "on";
    localparam logic [8*LEN_OFF-1:0]    STR_OFF    = "off";
    localparam logic [8*LEN_BOARD-1:0]  STR_BOARD  = "beagle";

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_UNKNOWN_CMD = 3'd1,
        EV_BAD_VERB    = 3'd2,
        EV_UNKNOWN_DEV = 3'd3,
        EV_POWER_SET   = 3'd4,
        EV_LCD         = 3'd5,
        EV_RESET       = 3'd6
    } ev_t;

    typedef enum logic [3:0] {
        PAT_MARKER     = 4'd0,
        PAT_POWER      = 4'd1,
        PAT_LCD        = 4'd2,
        PAT_RESET      = 4'd3,
        PAT_ON         = 4'd4,
        PAT_OFF        = 4'd5,
        PAT_ON_BOARD   = 4'd6,
        PAT_ON_PANEL   = 4'd7,
        PAT_OFF_BOARD  = 4'd8,
        PAT_OFF_PANEL  = 4'd9
    } pat_t;

    typedef struct packed {
        logic               line_end;
        logic [NUM_PAT-1:0] hit;
    } cmd_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

    function automatic logic [LEN_W-1:0] pat_start(pat_t pat);
        logic [LEN_W-1:0] s;
        s = '0;
        case (pat)
            PAT_MARKER:    s = '0;
            PAT_POWER:     s = LEN_W'(CMD_POS);
            PAT_LCD:       s = LEN_W'(CMD_POS);
            PAT_RESET:     s = LEN_W'(CMD_POS);
            PAT_ON:        s = LEN_W'(VERB_POS);
            PAT_OFF:       s = LEN_W'(VERB_POS);
            PAT_ON_BOARD:  s = LEN_W'(ON_DEV_POS);
            PAT_ON_PANEL:  s = LEN_W'(ON_DEV_POS);
            PAT_OFF_BOARD: s = LEN_W'(OFF_DEV_POS);
            PAT_OFF_PANEL: s = LEN_W'(OFF_DEV_POS);
            default:       s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [LEN_W-1:0] pat_end(pat_t pat);
        logic [LEN_W-1:0] e;
        e = '0;
        case (pat)
            PAT_MARKER:    e = LEN_W'(LEN_MARKER);
            PAT_POWER:     e = LEN_W'(CMD_POS + LEN_POWER);
            PAT_LCD:       e = LEN_W'(CMD_POS + LEN_LCD);
            PAT_RESET:     e = LEN_W'(CMD_POS + LEN_RESET);
            PAT_ON:        e = LEN_W'(VERB_POS + LEN_ON);
            PAT_OFF:       e = LEN_W'(VERB_POS + LEN_OFF);
            PAT_ON_BOARD:  e = LEN_W'(ON_DEV_POS + LEN_BOARD);
            PAT_ON_PANEL:  e = LEN_W'(ON_DEV_POS + LEN_LCD);
            PAT_OFF_BOARD: e = LEN_W'(OFF_DEV_POS + LEN_BOARD);
            PAT_OFF_PANEL: e = LEN_W'(OFF_DEV_POS + LEN_LCD);
            default:       e = '0;
        endcase
        return e;
    endfunction

    function automatic logic [7:0] pat_char(pat_t pat, logic [4:0] idx);
        logic [7:0] c;
        int         i;
        c = 8'h00;
        i = int'(idx);
        case (pat)
            PAT_MARKER:
                if (i < LEN_MARKER) c = STR_MARKER[8*(LEN_MARKER-1-i) +: 8];
            PAT_POWER:
                if (i < LEN_POWER) c = STR_POWER[8*(LEN_POWER-1-i) +: 8];
            PAT_LCD, PAT_ON_PANEL, PAT_OFF_PANEL:
                if (i < LEN_LCD) c = STR_LCD[8*(LEN_LCD-1-i) +: 8];
            PAT_RESET:
                if (i < LEN_RESET) c = STR_RESET[8*(LEN_RESET-1-i) +: 8];
            PAT_ON:
                if (i < LEN_ON) c = STR_ON[8*(LEN_ON-1-i) +: 8];
            PAT_OFF:
                if (i < LEN_OFF) c = STR_OFF[8*(LEN_OFF-1-i) +: 8];
            PAT_ON_BOARD, PAT_OFF_BOARD:
                if (i < LEN_BOARD) c = STR_BOARD[8*(LEN_BOARD-1-i) +: 8];
            default:
                c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[src/serial_line_command_recognizer_core.sv]
// An accepted byte's result is written into the queue first and then popped into the result
// register, which drives out_valid, event_res and power_pins.
// Throughput: one byte per cycle; the front matcher and the result register are decoupled
// by a two-entry queue, so input is stalled only while that queue is full.
// Reset clears the line count, the queue and both power pins, and sets all match flags.
module serial_line_command_recognizer_core
    import slcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic [1:0] power_pins
);

    logic      push;
    logic      pop;
    cmd_t      push_data;
    cmd_t      pop_data;
    q_status_t q_status;

    assign in_stall = q_status.full;
    assign push     = in_valid && !in_stall;

    slcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (push),
        .rx_byte   (rx_byte),
        .push_data (push_data)
    );

    slcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    slcr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .event_res  (event_res),
        .power_pins (power_pins)
    );

    // A full queue always sits behind a full result register.
    a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> out_valid)
        else $error("queue full while result register is empty");

    // The power pins change only together with a power-set event.
    a_pins_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(power_pins) |-> (out_valid && (event_res == EV_POWER_SET)))
        else $error("power pins changed without a power-set event");

endmodule

[src/slcr_front.sv]
module slcr_front
    import slcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output cmd_t       push_data
);

    // Each keyword is matched on the fly, one position per received byte, so
    // the line itself never has to be stored.
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic [NUM_PAT-1:0] run_reg;
    logic [NUM_PAT-1:0] run_next;
    logic [NUM_PAT-1:0] mismatch;
    logic [NUM_PAT-1:0] hit;
    logic               line_end;
    logic               kept;

    assign line_end = (rx_byte == BYTE_LF) || (rx_byte == BYTE_CR);
    assign kept     = len_reg < LEN_W'(HEAD_BYTES);

    for (genvar g = 0; g < NUM_PAT; g++) begin : g_pat
        localparam pat_t P = pat_t'(g);
        logic [LEN_W-1:0] rel;
        logic             in_range;

        assign rel         = len_reg - pat_start(P);
        assign in_range    = kept && (len_reg >= pat_start(P)) && (len_reg < pat_end(P));
        assign mismatch[g] = in_range && (rx_byte != pat_char(P, rel[4:0]));
        assign hit[g]      = run_reg[g] && (len_reg >= pat_end(P));
    end

    always_comb
    begin
        len_next = len_reg;
        run_next = run_reg;
        if (accept)
        begin
            if (line_end)
            begin
                len_next = '0;
                run_next = '1;
            end
            else if (kept)
            begin
                len_next = len_reg + 1'b1;
                run_next = run_reg & ~mismatch;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            run_reg <= '1;
        end
        else
        begin
            len_reg <= len_next;
            run_reg <= run_next;
        end
    end

    assign push_data.line_end = line_end;
    assign push_data.hit      = line_end ? hit : '0;

endmodule

[src/slcr_queue.sv]
module slcr_queue
    import slcr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_data,
    input  logic      pop,
    output cmd_t      pop_data,
    output q_status_t status
);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data         = slot_reg[rd_ptr_reg];
    assign status.not_empty = count_reg != '0;
    assign status.full      = count_reg == CNT_W'(QUEUE_DEPTH);

endmodule

[src/slcr_back.sv]
module slcr_back
    import slcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_status,
    input  cmd_t       pop_data,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [2:0] event_res,
    output logic [1:0] power_pins
);

    logic       valid_reg;
    logic       valid_next;
    ev_t        ev_reg;
    ev_t        ev_next;
    logic [1:0] power_reg;
    logic [1:0] power_next;
    ev_t        ev_dec;
    logic [1:0] pin_mask;
    logic       pin_on;
    logic [1:0] power_calc;

    assign pop = q_status.not_empty && (!valid_reg || !out_stall);

    always_comb
    begin
        ev_dec   = EV_NONE;
        pin_mask = '0;
        pin_on   = 1'b0;
        if (pop_data.line_end && pop_data.hit[PAT_MARKER])
        begin
            if (pop_data.hit[PAT_POWER])
            begin
                if (pop_data.hit[PAT_ON])
                begin
                    pin_on = 1'b1;
                    if (pop_data.hit[PAT_ON_BOARD])
                    begin
                        pin_mask = PIN_BOARD;
                        ev_dec   = EV_POWER_SET;
                    end
                    else if (pop_data.hit[PAT_ON_PANEL])
                    begin
                        pin_mask = PIN_PANEL;
                        ev_dec   = EV_POWER_SET;
                    end
                    else
                    begin
                        ev_dec = EV_UNKNOWN_DEV;
                    end
                end
                else if (pop_data.hit[PAT_OFF])
                begin
                    if (pop_data.hit[PAT_OFF_BOARD])
                    begin
                        pin_mask = PIN_BOARD;
                        ev_dec   = EV_POWER_SET;
                    end
                    else if (pop_data.hit[PAT_OFF_PANEL])
                    begin
                        pin_mask = PIN_PANEL;
                        ev_dec   = EV_POWER_SET;
                    end
                    else
                    begin
                        ev_dec = EV_UNKNOWN_DEV;
                    end
                end
                else
                begin
                    ev_dec = EV_BAD_VERB;
                end
            end
            else if (pop_data.hit[PAT_LCD])
            begin
                ev_dec = EV_LCD;
            end
            else if (pop_data.hit[PAT_RESET])
            begin
                ev_dec = EV_RESET;
            end
            else
            begin
                ev_dec = EV_UNKNOWN_CMD;
            end
        end
    end

    assign power_calc = pin_on ? (power_reg | pin_mask) : (power_reg & ~pin_mask);

    always_comb
    begin
        valid_next = valid_reg;
        ev_next    = ev_reg;
        power_next = power_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            ev_next    = ev_dec;
            power_next = power_calc;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ev_reg    <= EV_NONE;
            power_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ev_reg    <= ev_next;
            power_reg <= power_next;
        end
    end

    assign out_valid  = valid_reg;
    assign event_res  = ev_reg;
    assign power_pins = power_reg;

endmodule

[verif/slcr_checker.sv]
module slcr_checker
    import slcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [2:0] event_res,
    input  logic [1:0] power_pins,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CMD_AT  = 8;
    localparam int VERB_AT = CMD_AT + 6;

    typedef struct packed {
        ev_t        ev;
        logic [1:0] pins;
    } outcome_t;

    logic [7:0] line_bytes [HEAD_BYTES];
    int         line_len;
    logic [1:0] pin_state;
    outcome_t   outcomes_due [$];
    string      tag_txt;
    string      mark_txt;
    string      reset_txt;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        line_len   = 0;
        pin_state  = 2'b00;
        tag_txt    = $sformatf("%c%c%c", 8'h41, 8'h56, 8'h52);
        mark_txt   = {"#!# ", tag_txt};
        reset_txt  = {"REALLY reset the ", tag_txt};
    end

    task automatic report(input string what);
        $display("checker: %s at %0t", what, $time);
        fail_count++;
    endtask

    // A position past the kept part of the line never matches.
    function automatic bit text_at(input int pos, input string txt);
        int p;
        for (int i = 0; i < txt.len(); i++)
        begin
            p = pos + i;
            if (p >= line_len || p >= HEAD_BYTES)
                return 1'b0;
            if (line_bytes[p] != txt[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic ev_t run_power(input int pos);
        logic [1:0] pin;
        bit         turn_on;
        if (text_at(pos, "on"))
        begin
            turn_on = 1'b1;
            pos += 3;
        end
        else if (text_at(pos, "off"))
        begin
            turn_on = 1'b0;
            pos += 4;
        end
        else
            return EV_BAD_VERB;
        if (text_at(pos, "beagle"))
            pin = PIN_BOARD;
        else if (text_at(pos, "lcd"))
            pin = PIN_PANEL;
        else
            return EV_UNKNOWN_DEV;
        pin_state = turn_on ? (pin_state | pin) : (pin_state & ~pin);
        return EV_POWER_SET;
    endfunction

    function automatic ev_t close_line();
        if (!text_at(0, mark_txt))
            return EV_NONE;
        if (text_at(CMD_AT, "power"))
            return run_power(VERB_AT);
        if (text_at(CMD_AT, "lcd"))
            return EV_LCD;
        if (text_at(CMD_AT, reset_txt))
            return EV_RESET;
        return EV_UNKNOWN_CMD;
    endfunction

    function automatic outcome_t take_byte(input logic [7:0] b);
        outcome_t r;
        r.ev = EV_NONE;
        if (b == BYTE_LF || b == BYTE_CR)
        begin
            r.ev     = close_line();
            line_len = 0;
        end
        else if (line_len < HEAD_BYTES)
        begin
            line_bytes[line_len] = b;
            line_len++;
        end
        r.pins = pin_state;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            line_len  = 0;
            pin_state = 2'b00;
            outcomes_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (outcomes_due.size() == 0)
                    report("result beat with no byte outstanding");
                else
                begin
                    want = outcomes_due.pop_front();
                    if (event_res !== want.ev)
                        report($sformatf("event_res %0d, expected %0d", event_res, want.ev));
                    if (power_pins !== want.pins)
                        report($sformatf("power_pins %0d, expected %0d",
                                         power_pins, want.pins));
                end
            end
            if (in_valid && !in_stall)
                outcomes_due.push_back(take_byte(rx_byte));
        end
        pending = outcomes_due.size();
    end

endmodule

[verif/tb_serial_line_command_recognizer_core.sv]
module tb_serial_line_command_recognizer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import slcr_pkg::*;

    localparam int RUN_LIMIT    = 100000;
    localparam int RANDOM_BYTES = 1000;
    localparam int IDLE_PCT     = 7;
    localparam int HOLD_CYCLES  = 80;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] event_res;
    logic [1:0] power_pins;

    int           fail_count;
    int           pending;
    bit           calm       = 1'b0;
    int           hold_left  = 0;
    int           bytes_sent = 0;
    byte unsigned line_buf [$];
    string        tag_txt;
    string        mark_txt;
    string        reset_txt;

    serial_line_command_recognizer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_res  (event_res),
        .power_pins (power_pins)
    );

    slcr_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_res  (event_res),
        .power_pins (power_pins),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // The result side stalls at random, or holds off for a long stretch on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_sep();
        logic [7:0] s;
        s = 8'h20;
        if ($urandom_range(1) == 1)
        begin
            s = 8'($urandom_range(255));
            while (s == BYTE_LF || s == BYTE_CR)
                s = 8'($urandom_range(255));
        end
        return s;
    endfunction

    function automatic logic [7:0] pick_end();
        return ($urandom_range(1) == 1) ? BYTE_CR : BYTE_LF;
    endfunction

    task automatic send_line(input logic [7:0] term);
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        line_buf.delete();
        send_byte(term);
    endtask

    task automatic send_power(input string verb, input string device, input logic [7:0] sep);
        put_text(mark_txt);
        line_buf.push_back(sep);
        put_text("power");
        line_buf.push_back(sep);
        put_text(verb);
        line_buf.push_back(sep);
        put_text(device);
        send_line(pick_end());
    endtask

    task automatic send_command(input string cmd, input logic [7:0] term);
        put_text(mark_txt);
        line_buf.push_back(8'h20);
        put_text(cmd);
        send_line(term);
    endtask

    // Mostly well-formed command lines with random separators and damage, some noise.
    function automatic void make_line();
        int kind;
        int cut;
        kind = $urandom_range(99);
        if (kind < 78)
        begin
            put_text(mark_txt);
            line_buf.push_back(pick_sep());
            case ($urandom_range(7))
                0, 1, 2, 3:
                begin
                    put_text("power");
                    line_buf.push_back(pick_sep());
                    case ($urandom_range(9))
                        0:          put_text("up");
                        1:          put_text("of");
                        2, 3, 4, 5: put_text("on");
                        default:    put_text("off");
                    endcase
                    line_buf.push_back(pick_sep());
                    case ($urandom_range(7))
                        0:       put_text("bea");
                        1:       put_text("usb");
                        2, 3, 4: put_text("beagle");
                        default: put_text("lcd");
                    endcase
                end
                4:       put_text("lcd");
                5:       put_text(reset_txt);
                6:       put_text("REALLY reset");
                default: put_text("status");
            endcase
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 12))
                    line_buf.push_back(pick_sep());
            if ($urandom_range(9) == 0)
                line_buf[$urandom_range(line_buf.size() - 1)] = pick_sep();
            if ($urandom_range(9) == 0)
            begin
                cut = $urandom_range(line_buf.size());
                while (line_buf.size() > cut)
                    void'(line_buf.pop_back());
            end
        end
        else
        begin
            repeat ($urandom_range(40))
                line_buf.push_back(8'($urandom_range(255)));
        end
    endfunction

    initial
    begin
        int rand_start;
        tag_txt   = $sformatf("%c%c%c", 8'h41, 8'h56, 8'h52);
        mark_txt  = {"#!# ", tag_txt};
        reset_txt = {"REALLY reset the ", tag_txt};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_power("on", "beagle", 8'h20);
        send_power("on", "lcd", 8'h20);
        send_power("on", "lcd", 8'h20);
        send_power("off", "beagle", 8'h20);
        send_power("off", "lcd", 8'h5F);
        send_power("up", "lcd", 8'h20);
        send_power("on", "usb", 8'h20);
        send_command("lcd", BYTE_CR);
        send_command(reset_txt, BYTE_LF);
        send_command("reboot", BYTE_CR);
        send_command("power on", BYTE_LF);
        send_command("power", BYTE_CR);
        send_command("powerful on beagle", BYTE_LF);
        put_text(mark_txt);
        send_line(BYTE_LF);
        put_text("#!# ");
        put_text(tag_txt.substr(0, 1));
        send_line(BYTE_CR);
        put_text("hello");
        send_line(BYTE_LF);
        send_line(BYTE_CR);
        send_command("lcd", BYTE_CR);
        send_byte(BYTE_LF);
        put_text(mark_txt);
        put_text(" ");
        put_text(reset_txt);
        repeat (10)
        begin
            line_buf.push_back(8'hA5);
            line_buf.push_back(8'h5A);
        end
        send_line(BYTE_CR);
        repeat (40)
            line_buf.push_back(8'hFF);
        send_line(BYTE_LF);
        put_text(mark_txt);
        line_buf.push_back(8'h00);
        put_text("lcd");
        send_line(BYTE_LF);
        put_text(mark_txt);
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        put_text("cd");
        send_line(BYTE_CR);

        // The long hold-off fills the block while lines keep coming.
        hold_left  = HOLD_CYCLES;
        rand_start = bytes_sent;
        while (bytes_sent - rand_start < RANDOM_BYTES)
        begin
            calm = (bytes_sent - rand_start >= 500) && (bytes_sent - rand_start < 800);
            make_line();
            send_line(pick_end());
            if ($urandom_range(7) == 0)
                send_byte(BYTE_LF);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
src/slcr_pkg.sv
src/slcr_front.sv
src/slcr_queue.sv
src/slcr_back.sv
src/serial_line_command_recognizer_core.sv
verif/slcr_checker.sv
verif/tb_serial_line_command_recognizer_core.sv
